// ===== rtl/core/usbcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB control responder package
// Shared types, codes and default sizes for the low-speed control responder.
// ----------------------------------------------------------------------------
package usbcr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned ENDPOINT_COUNT_DEF = 4;
  localparam int unsigned DESC_ENTRIES_DEF   = 16;

  // Largest data payload of one low-speed packet, in bytes.
  localparam int unsigned MAX_PACKET = 8;

  // Standard request codes and the direction bit of bmRequestType.
  localparam logic [7:0]  REQ_SET_ADDRESS    = 8'h05;
  localparam logic [7:0]  REQ_GET_DESCRIPTOR = 8'h06;
  localparam int unsigned REQ_DIR_BIT        = 7;

  // Kind of bus event carried by one input item.
  typedef enum logic [2:0] {
    FUNC_SETUP = 3'd0,
    FUNC_IN    = 3'd1,
    FUNC_OUT   = 3'd2,
    FUNC_DATA  = 3'd3,
    FUNC_ACK   = 3'd4,
    FUNC_LOAD  = 3'd5
  } func_e;

  // Packet the device answers with.
  typedef enum logic [1:0] {
    PID_DATA0 = 2'd0,
    PID_DATA1 = 2'd1,
    PID_NAK   = 2'd2,
    PID_ACK   = 2'd3
  } pid_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

  // One input item.
  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  device_address;
    logic [3:0]  endpoint;
    logic        data_toggle;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    logic [3:0]  desc_slot;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  response_pid;
    logic [3:0]  payload_length;
    logic [3:0]  descriptor_select;
    logic [15:0] byte_offset;
  } rsp_t;

  // One descriptor table entry.
  typedef struct packed {
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
  } desc_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic search_run;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;
    logic starts_search;
    logic search_done;
  } status_t;

endpackage

// ===== rtl/core/usbcr_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB control responder request channel
// Valid/ready channel that carries one decoded bus event per item.
// ----------------------------------------------------------------------------
interface usbcr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [6:0]  device_address;
  logic [3:0]  endpoint;
  logic        data_toggle;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_index;
  logic [15:0] request_length;
  logic [3:0]  desc_slot;

  modport source (
    output valid, func, device_address, endpoint, data_toggle, request_type,
           request_code, request_value, request_index, request_length, desc_slot,
    input  ready
  );

  modport sink (
    input  valid, func, device_address, endpoint, data_toggle, request_type,
           request_code, request_value, request_index, request_length, desc_slot,
    output ready
  );
endinterface

// ===== rtl/core/usbcr_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB control responder response channel
// Valid/ready channel that carries one packet to send per item.
// ----------------------------------------------------------------------------
interface usbcr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  response_pid;
  logic [3:0]  payload_length;
  logic [3:0]  descriptor_select;
  logic [15:0] byte_offset;

  modport source (
    output valid, response_pid, payload_length, descriptor_select, byte_offset,
    input  ready
  );

  modport sink (
    input  valid, response_pid, payload_length, descriptor_select, byte_offset,
    output ready
  );
endinterface

// ===== rtl/core/usb_control_transaction_responder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB control transaction responder
// Low-speed control endpoint responder working on decoded bus events.
// ----------------------------------------------------------------------------
// Usage:
// Request items on req_i carry one decoded event each: a SETUP, IN or OUT
// token, a DATA packet, an ACK handshake, or a descriptor table load.
// Response items on rsp_o give the packet to send: ACK for every DATA item,
// DATA0/DATA1 with descriptor slot, byte offset and length for IN tokens on
// endpoint zero, and NAK for IN tokens on other endpoints.
// The result is registered and is valid in the cycle after its item is taken.
// Throughput: one item per cycle, except that a Get Descriptor setup packet
// runs the table search over the descriptor memory port, one entry a cycle;
// the input then stays closed until the search matches an entry or has
// compared the last entry without a match.
// A single output register holds the result; while the receiver stalls,
// no new item is taken until that result leaves.
// Reset clears all device and endpoint state; the descriptor table keeps
// whatever it holds and must be loaded before Get Descriptor is used.
// ----------------------------------------------------------------------------
module usb_control_transaction_responder_unit #(
  parameter int unsigned ENDPOINT_COUNT = usbcr_pkg::ENDPOINT_COUNT_DEF,
  parameter int unsigned DESC_ENTRIES   = usbcr_pkg::DESC_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  usbcr_req_if.sink   req_i,
  usbcr_rsp_if.source rsp_o
);

  usbcr_pkg::req_t    req;
  usbcr_pkg::rsp_t    rsp;
  usbcr_pkg::cmd_t    cmd;
  usbcr_pkg::status_t status;

  // Gather the request payload.
  always_comb begin
    req.func           = req_i.func;
    req.device_address = req_i.device_address;
    req.endpoint       = req_i.endpoint;
    req.data_toggle    = req_i.data_toggle;
    req.request_type   = req_i.request_type;
    req.request_code   = req_i.request_code;
    req.request_value  = req_i.request_value;
    req.request_index  = req_i.request_index;
    req.request_length = req_i.request_length;
    req.desc_slot      = req_i.desc_slot;
  end

  usbcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  usbcr_datapath #(
    .ENDPOINT_COUNT (ENDPOINT_COUNT),
    .DESC_ENTRIES   (DESC_ENTRIES)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .cmd_i    (cmd),
    .status_o (status),
    .rsp_o    (rsp)
  );

  // Drive the response payload.
  assign rsp_o.response_pid      = rsp.response_pid;
  assign rsp_o.payload_length    = rsp.payload_length;
  assign rsp_o.descriptor_select = rsp.descriptor_select;
  assign rsp_o.byte_offset       = rsp.byte_offset;

endmodule

// ===== rtl/core/usbcr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB control responder controller
// Sequences item intake, the descriptor table search and the output register.
// ----------------------------------------------------------------------------
module usbcr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  usbcr_pkg::status_t status_i,
  output usbcr_pkg::cmd_t    cmd_o
);

  usbcr_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              take;

  // Items are taken only when idle and the output register is free or draining.
  always_comb begin
    in_ready_o       = (state_q == usbcr_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
    take             = in_valid_i && in_ready_o;
    cmd_o.take_item  = take;
    cmd_o.search_run = (state_q == usbcr_pkg::ST_SEARCH);
  end

  // Next state: a Get Descriptor request runs the table search.
  always_comb begin
    state_d = state_q;
    case (state_q)
      usbcr_pkg::ST_IDLE: begin
        if (take && status_i.starts_search) begin
          state_d = usbcr_pkg::ST_SEARCH;
        end
      end
      usbcr_pkg::ST_SEARCH: begin
        if (status_i.search_done) begin
          state_d = usbcr_pkg::ST_IDLE;
        end
      end
      default: state_d = usbcr_pkg::ST_IDLE;
    endcase
  end

  // The output register is full from a loading item until the sink takes it.
  always_comb begin
    if (take && status_i.has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= usbcr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/usbcr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB control responder datapath
// Device and endpoint state, descriptor table memory, search and result.
// ----------------------------------------------------------------------------
module usbcr_datapath #(
  parameter int unsigned ENDPOINT_COUNT = usbcr_pkg::ENDPOINT_COUNT_DEF,
  parameter int unsigned DESC_ENTRIES   = usbcr_pkg::DESC_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  usbcr_pkg::req_t    req_i,
  input  usbcr_pkg::cmd_t    cmd_i,
  output usbcr_pkg::status_t status_o,
  output usbcr_pkg::rsp_t    rsp_o
);

  localparam int unsigned EW = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
  localparam int unsigned AW = (DESC_ENTRIES > 1) ? $clog2(DESC_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DESC_ENTRIES - 1);

  // Device state.
  logic [6:0]  own_addr_q, own_addr_d;
  logic [EW-1:0] active_ep_q, active_ep_d;
  logic        setup_pend_q, setup_pend_d;
  logic [15:0] ctl_len_q, ctl_len_d;

  // Per-endpoint state.
  logic        tog_out_q [ENDPOINT_COUNT];
  logic        tog_out_d [ENDPOINT_COUNT];
  logic        tog_in_q  [ENDPOINT_COUNT];
  logic        tog_in_d  [ENDPOINT_COUNT];
  logic [12:0] pkt_cnt_q [ENDPOINT_COUNT];
  logic [12:0] pkt_cnt_d [ENDPOINT_COUNT];
  logic        sending_q [ENDPOINT_COUNT];
  logic        sending_d [ENDPOINT_COUNT];
  logic [3:0]  chosen_q  [ENDPOINT_COUNT];
  logic [3:0]  chosen_d  [ENDPOINT_COUNT];

  // Descriptor table and search pipeline.
  usbcr_pkg::desc_entry_t desc_mem [DESC_ENTRIES];
  usbcr_pkg::desc_entry_t rd_q;
  logic [AW-1:0] scan_addr_q;
  logic [AW-1:0] rd_idx_q;
  logic          rd_vld_q;
  logic [15:0]   key_value_q, key_index_q, key_length_q;
  logic [EW-1:0] key_ep_q;

  // Result register.
  usbcr_pkg::rsp_t rsp_q, rsp_d;

  logic          tok_ok;
  logic [EW-1:0] ep_idx;
  logic [EW-1:0] cur;
  logic          load_ok;
  logic          rd_match;
  logic [15:0]   found_len;
  logic [15:0]   in_off;
  logic [15:0]   in_rem;
  logic          is_get_desc;

  assign ep_idx = EW'(req_i.endpoint);
  assign cur    = active_ep_q;

  // A token counts when it names an existing endpoint of this device.
  assign tok_ok = (32'(req_i.endpoint) < ENDPOINT_COUNT) &&
                  ((req_i.device_address == 7'd0) || (req_i.device_address == own_addr_q));

  assign load_ok = (32'(req_i.desc_slot) < DESC_ENTRIES);

  // A setup packet that will be decoded as Get Descriptor starts a search.
  assign is_get_desc = (tog_out_q[cur] == req_i.data_toggle) && setup_pend_q &&
                       req_i.request_type[usbcr_pkg::REQ_DIR_BIT] &&
                       (req_i.request_code == usbcr_pkg::REQ_GET_DESCRIPTOR);

  // Search compare on the registered table read.
  assign rd_match  = (rd_q.index == key_index_q) && (rd_q.value == key_value_q);
  assign found_len = (key_length_q < rd_q.length) ? key_length_q : rd_q.length;

  always_comb begin
    status_o.has_result    = ((req_i.func == usbcr_pkg::FUNC_IN) && tok_ok) ||
                             (req_i.func == usbcr_pkg::FUNC_DATA);
    status_o.starts_search = (req_i.func == usbcr_pkg::FUNC_DATA) && is_get_desc;
    status_o.search_done   = rd_vld_q && (rd_match || (rd_idx_q == LAST_ADDR));
  end

  // Data packet for endpoint zero: the next slice of the chosen descriptor.
  assign in_off = {pkt_cnt_q[0], 3'b000};
  assign in_rem = ctl_len_q - in_off;

  always_comb begin
    rsp_d = '0;
    if (req_i.func == usbcr_pkg::FUNC_DATA) begin
      rsp_d.response_pid = usbcr_pkg::PID_ACK;
    end else if (ep_idx != '0 || req_i.endpoint != 4'd0) begin
      rsp_d.response_pid = usbcr_pkg::PID_NAK;
    end else begin
      rsp_d.response_pid = tog_in_q[0] ? usbcr_pkg::PID_DATA1 : usbcr_pkg::PID_DATA0;
      if (sending_q[0]) begin
        rsp_d.byte_offset       = in_off;
        rsp_d.descriptor_select = chosen_q[0];
        if (ctl_len_q > in_off) begin
          if (in_rem > 16'(usbcr_pkg::MAX_PACKET)) begin
            rsp_d.payload_length = 4'(usbcr_pkg::MAX_PACKET);
          end else begin
            rsp_d.payload_length = in_rem[3:0];
          end
        end
      end
    end
  end

  // Next state of the device and endpoint registers.
  always_comb begin
    own_addr_d   = own_addr_q;
    active_ep_d  = active_ep_q;
    setup_pend_d = setup_pend_q;
    ctl_len_d    = ctl_len_q;
    for (int i = 0; i < ENDPOINT_COUNT; i++) begin
      tog_out_d[i] = tog_out_q[i];
      tog_in_d[i]  = tog_in_q[i];
      pkt_cnt_d[i] = pkt_cnt_q[i];
      sending_d[i] = sending_q[i];
      chosen_d[i]  = chosen_q[i];
    end

    if (cmd_i.take_item) begin
      case (req_i.func)
        usbcr_pkg::FUNC_SETUP: begin
          if (tok_ok) begin
            active_ep_d       = ep_idx;
            tog_out_d[ep_idx] = 1'b0;
            tog_in_d[ep_idx]  = 1'b1;
            pkt_cnt_d[ep_idx] = '0;
            setup_pend_d      = 1'b1;
          end
        end
        usbcr_pkg::FUNC_IN: begin
          if (tok_ok) begin
            active_ep_d = ep_idx;
          end
        end
        usbcr_pkg::FUNC_OUT: begin
          if (tok_ok) begin
            active_ep_d       = ep_idx;
            pkt_cnt_d[ep_idx] = '0;
          end
        end
        usbcr_pkg::FUNC_DATA: begin
          if (tog_out_q[cur] == req_i.data_toggle) begin
            tog_out_d[cur] = ~req_i.data_toggle;
            if (setup_pend_q) begin
              setup_pend_d   = 1'b0;
              pkt_cnt_d[cur] = '0;
              sending_d[cur] = 1'b0;
              chosen_d[cur]  = '0;
              // Set Address applies at once; Get Descriptor goes to the search.
              if (!req_i.request_type[usbcr_pkg::REQ_DIR_BIT] &&
                  (req_i.request_type == 8'd0) &&
                  (req_i.request_code == usbcr_pkg::REQ_SET_ADDRESS)) begin
                own_addr_d = req_i.request_value[6:0];
              end
            end
          end
        end
        usbcr_pkg::FUNC_ACK: begin
          tog_in_d[cur]  = ~tog_in_q[cur];
          pkt_cnt_d[cur] = pkt_cnt_q[cur] + 13'd1;
        end
        default: begin
        end
      endcase
    end

    // A search hit selects the descriptor and clips the control length.
    if (cmd_i.search_run && rd_vld_q && rd_match) begin
      chosen_d[key_ep_q]  = 4'(rd_idx_q);
      sending_d[key_ep_q] = 1'b1;
      ctl_len_d           = found_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q   <= '0;
      active_ep_q  <= '0;
      setup_pend_q <= 1'b0;
      ctl_len_q    <= '0;
      for (int i = 0; i < ENDPOINT_COUNT; i++) begin
        tog_out_q[i] <= 1'b0;
        tog_in_q[i]  <= 1'b0;
        pkt_cnt_q[i] <= '0;
        sending_q[i] <= 1'b0;
        chosen_q[i]  <= '0;
      end
    end else begin
      own_addr_q   <= own_addr_d;
      active_ep_q  <= active_ep_d;
      setup_pend_q <= setup_pend_d;
      ctl_len_q    <= ctl_len_d;
      for (int i = 0; i < ENDPOINT_COUNT; i++) begin
        tog_out_q[i] <= tog_out_d[i];
        tog_in_q[i]  <= tog_in_d[i];
        pkt_cnt_q[i] <= pkt_cnt_d[i];
        sending_q[i] <= sending_d[i];
        chosen_q[i]  <= chosen_d[i];
      end
    end
  end

  // Search control: one table read per cycle, compared in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      scan_addr_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.search_run && !status_o.search_done;
      if (cmd_i.take_item) begin
        scan_addr_q <= '0;
      end else if (cmd_i.search_run && (scan_addr_q != LAST_ADDR)) begin
        scan_addr_q <= scan_addr_q + AW'(1);
      end
    end
  end

  // Search key, captured with the setup packet.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && status_o.starts_search) begin
      key_value_q  <= req_i.request_value;
      key_index_q  <= req_i.request_index;
      key_length_q <= req_i.request_length;
      key_ep_q     <= cur;
    end
  end

  // Descriptor table memory: written by load items, read by the search.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && (req_i.func == usbcr_pkg::FUNC_LOAD) && load_ok) begin
      desc_mem[AW'(req_i.desc_slot)] <= '{value:  req_i.request_value,
                                          index:  req_i.request_index,
                                          length: req_i.request_length};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q     <= desc_mem[scan_addr_q];
    rd_idx_q <= scan_addr_q;
  end

  // Result register, loaded by every item that answers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && status_o.has_result) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== bench/usb_control_transaction_responder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB control transaction responder testbench
// Loads the descriptor table, runs a directed set of control transfers and
// corner cases, and then runs random control transfers mixed with table
// loads and noise events. A scoreboard tracks the device and endpoint state,
// predicts every response packet and checks each one in order. The bus
// events and the responses are throttled at random, and in one phase the
// receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module usb_control_transaction_responder_unit_tb;
  import usbcr_pkg::*;

  localparam int unsigned EP_COUNT      = ENDPOINT_COUNT_DEF;
  localparam int unsigned DESC_SLOTS    = DESC_ENTRIES_DEF;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_LIMIT   = 10000;
  localparam int unsigned SETTLE_CYCLES = 24;

  // Tracks the responder state and the response packets still owed.
  class ctrl_xfer_scoreboard;
    logic [6:0]   own_addr;
    logic [1:0]   cur_ep;
    logic         setup_armed;
    logic [15:0]  xfer_len;
    logic         out_tog[EP_COUNT];
    logic         in_tog[EP_COUNT];
    logic [12:0]  in_pkts[EP_COUNT];
    logic         desc_active[EP_COUNT];
    logic [3:0]   desc_sel[EP_COUNT];
    desc_entry_t  desc_tab[DESC_SLOTS];
    rsp_t         pending_packets[$];
    int unsigned  accepted_events;
    int unsigned  checked_packets;
    int unsigned  ack_packets;
    int unsigned  data_packets;
    int unsigned  nak_packets;
    int unsigned  desc_hits;
    int unsigned  mismatches;

    // Device state after reset; the table stays unknown until loaded.
    function void clear_state();
      own_addr    = '0;
      cur_ep      = '0;
      setup_armed = 1'b0;
      xfer_len    = '0;
      for (int e = 0; e < EP_COUNT; e++) begin
        out_tog[e]     = 1'b0;
        in_tog[e]      = 1'b0;
        in_pkts[e]     = '0;
        desc_active[e] = 1'b0;
        desc_sel[e]    = '0;
      end
    endfunction

    // Applies one accepted bus event and queues the packet it calls for.
    function void note_event(input req_t ev);
      rsp_t        pkt;
      logic        has_pkt;
      logic        tok_ok;
      logic        found;
      logic [1:0]  ep;
      logic [15:0] off;
      logic [15:0] left;
      int unsigned hit;
      accepted_events++;
      pkt     = '0;
      has_pkt = 1'b0;
      found   = 1'b0;
      hit     = 0;
      ep      = ev.endpoint[1:0];
      tok_ok  = (ev.endpoint < EP_COUNT) &&
                (ev.device_address == 7'd0 || ev.device_address == own_addr);
      case (ev.func)
        FUNC_SETUP: begin
          if (tok_ok) begin
            cur_ep      = ep;
            out_tog[ep] = 1'b0;
            in_tog[ep]  = 1'b1;
            in_pkts[ep] = '0;
            setup_armed = 1'b1;
          end
        end
        FUNC_IN: begin
          if (tok_ok) begin
            cur_ep  = ep;
            has_pkt = 1'b1;
            if (ev.endpoint != 4'd0) begin
              pkt.response_pid = PID_NAK;
            end else begin
              pkt.response_pid = in_tog[0] ? PID_DATA1 : PID_DATA0;
              if (desc_active[0]) begin
                off                   = {in_pkts[0], 3'b000};
                pkt.byte_offset       = off;
                pkt.descriptor_select = desc_sel[0];
                if (xfer_len > off) begin
                  left               = xfer_len - off;
                  pkt.payload_length = (left > MAX_PACKET) ? 4'(MAX_PACKET) : left[3:0];
                end
              end
            end
          end
        end
        FUNC_OUT: begin
          if (tok_ok) begin
            cur_ep      = ep;
            in_pkts[ep] = '0;
          end
        end
        FUNC_DATA: begin
          // A matching toggle advances it; a pending setup is then decoded.
          if (out_tog[cur_ep] == ev.data_toggle) begin
            out_tog[cur_ep] = ~ev.data_toggle;
            if (setup_armed) begin
              setup_armed         = 1'b0;
              in_pkts[cur_ep]     = '0;
              desc_active[cur_ep] = 1'b0;
              desc_sel[cur_ep]    = '0;
              if (ev.request_type[REQ_DIR_BIT]) begin
                if (ev.request_code == REQ_GET_DESCRIPTOR) begin
                  for (int s = 0; s < DESC_SLOTS; s++) begin
                    if (!found && desc_tab[s].index == ev.request_index &&
                        desc_tab[s].value == ev.request_value) begin
                      found = 1'b1;
                      hit   = s;
                    end
                  end
                  if (found) begin
                    desc_hits++;
                    desc_sel[cur_ep]    = 4'(hit);
                    desc_active[cur_ep] = 1'b1;
                    xfer_len = (ev.request_length < desc_tab[hit].length) ?
                               ev.request_length : desc_tab[hit].length;
                  end
                end
              end else if (ev.request_type == 8'h00) begin
                if (ev.request_code == REQ_SET_ADDRESS) own_addr = ev.request_value[6:0];
              end
            end
          end
          has_pkt          = 1'b1;
          pkt.response_pid = PID_ACK;
        end
        FUNC_ACK: begin
          in_tog[cur_ep]  = ~in_tog[cur_ep];
          in_pkts[cur_ep] = in_pkts[cur_ep] + 13'd1;
        end
        FUNC_LOAD: begin
          desc_tab[ev.desc_slot].value  = ev.request_value;
          desc_tab[ev.desc_slot].index  = ev.request_index;
          desc_tab[ev.desc_slot].length = ev.request_length;
        end
        default: begin
          // Unused event codes leave the device untouched.
        end
      endcase
      if (has_pkt) pending_packets.push_back(pkt);
    endfunction

    function void compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Checks one response packet against the oldest one owed.
    function void check_packet(input rsp_t got);
      rsp_t want;
      if (pending_packets.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response, expected none, actual pid %0h len %0h sel %0h off %0h",
                 $time, got.response_pid, got.payload_length, got.descriptor_select,
                 got.byte_offset);
        return;
      end
      want = pending_packets.pop_front();
      checked_packets++;
      compare_field("response_pid", 16'(want.response_pid), 16'(got.response_pid));
      compare_field("payload_length", 16'(want.payload_length), 16'(got.payload_length));
      compare_field("descriptor_select", 16'(want.descriptor_select),
                    16'(got.descriptor_select));
      compare_field("byte_offset", want.byte_offset, got.byte_offset);
      case (want.response_pid)
        PID_ACK: ack_packets++;
        PID_NAK: nak_packets++;
        default: data_packets++;
      endcase
    endfunction
  endclass

  logic clk;
  logic rst_n;

  usbcr_req_if req_bus ();
  usbcr_rsp_if rsp_bus ();

  usb_control_transaction_responder_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  ctrl_xfer_scoreboard sb;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_requests;
  int unsigned holds_served;
  int unsigned hold_left;
  int unsigned sent_count;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit.
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Response ready: random stalls, plus a long hold-off when one is requested.
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Response monitor: values are stable at the falling edge.
  always @(negedge clk) begin
    rsp_t got;
    if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got.response_pid      = rsp_bus.response_pid;
      got.payload_length    = rsp_bus.payload_length;
      got.descriptor_select = rsp_bus.descriptor_select;
      got.byte_offset       = rsp_bus.byte_offset;
      sb.check_packet(got);
    end
  end

  function automatic req_t random_event();
    req_t ev;
    ev.func           = 3'($urandom_range(7));
    ev.device_address = 7'($urandom);
    ev.endpoint       = 4'($urandom);
    ev.data_toggle    = 1'($urandom);
    ev.request_type   = 8'($urandom);
    ev.request_code   = 8'($urandom);
    ev.request_value  = 16'($urandom);
    ev.request_index  = 16'($urandom);
    ev.request_length = 16'($urandom);
    ev.desc_slot      = 4'($urandom);
    return ev;
  endfunction

  // Token address: mostly the default or the assigned address.
  function automatic logic [6:0] pick_address();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return 7'd0;
    if (pick < 90) return sb.own_addr;
    return 7'($urandom);
  endfunction

  task automatic drive_fields(input req_t ev);
    req_bus.func           <= ev.func;
    req_bus.device_address <= ev.device_address;
    req_bus.endpoint       <= ev.endpoint;
    req_bus.data_toggle    <= ev.data_toggle;
    req_bus.request_type   <= ev.request_type;
    req_bus.request_code   <= ev.request_code;
    req_bus.request_value  <= ev.request_value;
    req_bus.request_index  <= ev.request_index;
    req_bus.request_length <= ev.request_length;
    req_bus.desc_slot      <= ev.desc_slot;
  endtask

  // Offers one item, waits for its handshake and hands it to the scoreboard.
  task automatic send_event(input req_t ev);
    logic fire;
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    drive_fields(ev);
    req_bus.valid <= 1'b1;
    fire = 1'b0;
    while (!fire) begin
      @(negedge clk);
      fire = (req_bus.ready === 1'b1);
      @(posedge clk);
    end
    sb.note_event(ev);
    sent_count++;
  endtask

  task automatic send_token(input func_e fn, input logic [6:0] addr, input logic [3:0] ep);
    req_t ev;
    ev                = random_event();
    ev.func           = fn;
    ev.device_address = addr;
    ev.endpoint       = ep;
    send_event(ev);
  endtask

  task automatic send_data(input logic tog, input logic [7:0] rtype, input logic [7:0] rcode,
                           input logic [15:0] val, input logic [15:0] idx,
                           input logic [15:0] len);
    req_t ev;
    ev                = random_event();
    ev.func           = FUNC_DATA;
    ev.data_toggle    = tog;
    ev.request_type   = rtype;
    ev.request_code   = rcode;
    ev.request_value  = val;
    ev.request_index  = idx;
    ev.request_length = len;
    send_event(ev);
  endtask

  task automatic send_ack();
    req_t ev;
    ev      = random_event();
    ev.func = FUNC_ACK;
    send_event(ev);
  endtask

  task automatic load_slot(input logic [3:0] slot, input logic [15:0] val,
                           input logic [15:0] idx, input logic [15:0] len);
    req_t ev;
    ev                = random_event();
    ev.func           = FUNC_LOAD;
    ev.desc_slot      = slot;
    ev.request_value  = val;
    ev.request_index  = idx;
    ev.request_length = len;
    send_event(ev);
  endtask

  // One control transfer with random content: setup, data, IN packets, status.
  task automatic run_control_xfer();
    logic [3:0]  ep;
    logic [7:0]  rtype;
    logic [7:0]  rcode;
    logic [15:0] val;
    logic [15:0] idx;
    logic [15:0] len;
    int unsigned pick;
    int unsigned slot;
    int unsigned n_in;
    ep = ($urandom_range(9) < 8) ? 4'd0 : 4'($urandom_range(15));
    send_token(FUNC_SETUP, pick_address(), ep);
    pick = $urandom_range(99);
    idx  = 16'($urandom);
    len  = 16'($urandom);
    if (pick < 60) begin
      slot  = $urandom_range(DESC_SLOTS - 1);
      rtype = ($urandom_range(3) == 0) ? (8'($urandom) | 8'h80) : 8'h80;
      rcode = REQ_GET_DESCRIPTOR;
      if ($urandom_range(99) < 85) begin
        val = sb.desc_tab[slot].value;
        idx = sb.desc_tab[slot].index;
      end else begin
        val = 16'($urandom);
      end
      if ($urandom_range(9) < 6) len = 16'($urandom_range(40));
      else if ($urandom_range(9) < 8) len = 16'($urandom_range(300));
      n_in = $urandom_range(12);
    end else if (pick < 80) begin
      rtype = 8'h00;
      rcode = REQ_SET_ADDRESS;
      val   = 16'($urandom);
      n_in  = $urandom_range(3);
    end else begin
      rtype = 8'($urandom);
      rcode = 8'($urandom);
      val   = 16'($urandom);
      n_in  = $urandom_range(3);
    end
    send_data(($urandom_range(9) == 0), rtype, rcode, val, idx, len);
    repeat (n_in) begin
      send_token(FUNC_IN, pick_address(),
                 ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'd0);
      if ($urandom_range(9) != 0) send_ack();
    end
    send_token(FUNC_OUT, pick_address(), ep);
    send_data(1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  // Random traffic until the given number of further items has been taken.
  task automatic run_random(input int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    target = sent_count + n_items;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_control_xfer();
      end else if (pick < 80) begin
        load_slot(4'($urandom), 16'h0100 + 16'($urandom_range(23)),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000,
                  ($urandom_range(9) < 7) ? 16'($urandom_range(64)) : 16'($urandom));
      end else begin
        send_event(random_event());
      end
    end
  endtask

  // Main sequence.
  initial begin
    req_t        ev;
    int unsigned drain;
    rst_n          = 1'b0;
    src_idle_pct   = 37;
    sink_idle_pct  = 68;
    hold_requests  = 0;
    holds_served   = 0;
    hold_left      = 0;
    sent_count     = 0;
    sb             = new;
    sb.clear_state();
    req_bus.valid <= 1'b0;
    drive_fields('0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every table slot first, with the key extremes and a duplicate key.
    for (int s = 0; s < DESC_SLOTS; s++) begin
      case (s)
        0:       load_slot(4'(s), 16'h0000, 16'h0000, 16'h0000);
        9:       load_slot(4'(s), 16'h0104, 16'h0000, 16'd40);
        15:      load_slot(4'(s), 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: load_slot(4'(s), 16'h0100 + 16'(s), 16'h0000, 16'(s * 6));
      endcase
    end

    // IN before any setup, then DATA with a wrong and a right toggle.
    send_token(FUNC_IN, 7'd0, 4'd0);
    send_data(1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    send_data(1'b0, 8'h80, REQ_GET_DESCRIPTOR, 16'h0103, 16'h0000, 16'hFFFF);

    // Get Descriptor clipped to the stored length, read out to past its end.
    send_token(FUNC_SETUP, 7'd0, 4'd0);
    send_data(1'b0, 8'h80, REQ_GET_DESCRIPTOR, 16'h0103, 16'h0000, 16'hFFFF);
    repeat (4) begin
      send_token(FUNC_IN, 7'd0, 4'd0);
      send_ack();
    end
    send_token(FUNC_OUT, 7'd0, 4'd0);
    send_data(1'b1, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);

    // Duplicate key resolves to the lower slot; requested length is shorter.
    send_token(FUNC_SETUP, 7'd0, 4'd0);
    send_data(1'b0, 8'h80, REQ_GET_DESCRIPTOR, 16'h0104, 16'h0000, 16'd5);
    send_token(FUNC_IN, 7'd0, 4'd0);

    // Toggle mismatch leaves the setup pending; Set Address to the top value.
    send_token(FUNC_SETUP, 7'd0, 4'd0);
    send_data(1'b1, 8'h00, REQ_SET_ADDRESS, 16'h0011, 16'h0000, 16'h0000);
    send_data(1'b0, 8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // NAK on a non-control endpoint; foreign address and endpoint ignored.
    send_token(FUNC_IN, 7'h7F, 4'd3);
    send_token(FUNC_IN, 7'h12, 4'd0);
    send_token(FUNC_IN, 7'd0, 4'd15);
    ev      = random_event();
    ev.func = 3'd6;
    send_event(ev);
    ev.func = 3'd7;
    send_event(ev);

    // Descriptor not found.
    send_token(FUNC_SETUP, 7'h7F, 4'd0);
    send_data(1'b0, 8'h80, REQ_GET_DESCRIPTOR, 16'h0777, 16'h1234, 16'd64);
    send_token(FUNC_IN, 7'h7F, 4'd0);

    // Largest key on another endpoint, then a request that changes nothing.
    send_token(FUNC_SETUP, 7'd0, 4'd2);
    send_data(1'b0, 8'hFF, REQ_GET_DESCRIPTOR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_token(FUNC_IN, 7'd0, 4'd2);
    send_ack();
    send_token(FUNC_SETUP, 7'd0, 4'd0);
    send_data(1'b0, 8'h40, REQ_SET_ADDRESS, 16'h0055, 16'h0000, 16'h0000);

    // Random phases: receiver-light, sender-light, then full rate.
    run_random(600);
    src_idle_pct  = 68;
    sink_idle_pct = 37;
    run_random(600);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_requests++;
    run_random(600);
    req_bus.valid <= 1'b0;

    // Drain the outstanding responses, then watch for strays.
    drain = 0;
    while (sb.pending_packets.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_packets.size() != 0) begin
      sb.mismatches++;
      $display("%0t: %0d responses never arrived, expected 0 outstanding, actual %0d",
               $time, sb.pending_packets.size(), sb.pending_packets.size());
    end

    $display("Run covered %0d bus events and %0d responses: %0d ACK, %0d DATA, %0d NAK.",
             sb.accepted_events, sb.checked_packets, sb.ack_packets, sb.data_packets,
             sb.nak_packets);
    $display("Descriptor searches that matched: %0d; long receiver hold-offs: %0d.",
             sb.desc_hits, hold_requests);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
